### hdl/lpwa_pkg.sv
package lpwa_pkg;

    // field widths
    localparam int DATA_W   = 16;
    localparam int WIN_W    = 4;
    localparam int CNT_W    = 16;
    localparam int NUM_COMP = 4;
    localparam int COMP_W   = 2;

    localparam logic [WIN_W-1:0]  WIN_RESET = 4'd6;
    localparam logic [CNT_W-1:0]  CNT_MAX   = 16'hFFFF;
    localparam logic [COMP_W-1:0] COMP_LAST = 2'd3;

    // one ring entry: dir_x, dir_y, base_x, base_y in slots 0 to 3
    typedef logic [NUM_COMP-1:0][DATA_W-1:0] lpwa_vec_t;

    // input beat
    typedef struct packed {
        logic                     lane_group;
        logic                     lane_present;
        logic                     measure_valid;
        logic                     override_on;
        logic signed [DATA_W-1:0] dir_x;
        logic signed [DATA_W-1:0] dir_y;
        logic signed [DATA_W-1:0] base_x;
        logic signed [DATA_W-1:0] base_y;
        logic signed [DATA_W-1:0] ovr_dir_x;
        logic signed [DATA_W-1:0] ovr_dir_y;
        logic signed [DATA_W-1:0] ovr_base_x;
        logic signed [DATA_W-1:0] ovr_base_y;
    } lpwa_in_t;

    // output beat
    typedef struct packed {
        logic                     out_group;
        logic                     average_valid;
        logic signed [DATA_W-1:0] avg_dir_x;
        logic signed [DATA_W-1:0] avg_dir_y;
        logic signed [DATA_W-1:0] avg_base_x;
        logic signed [DATA_W-1:0] avg_base_y;
        logic [CNT_W-1:0]         entry_count;
    } lpwa_out_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MEAS,
        S_OVR,
        S_DECIDE,
        S_FILL,
        S_READ,
        S_DRAIN,
        S_DIV_START,
        S_DIV_WAIT,
        S_OUT
    } lpwa_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic meas_step;
        logic ovr_step;
        logic decide;
        logic fill;
        logic read;
        logic div_start;
        logic lane_next;
        logic load_out;
    } lpwa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fill_all;
        logic avg_now;
        logic ovr_item;
        logic sweep_last;
        logic div_done;
        logic lane_last;
        logic out_free;
    } lpwa_stat_t;

endpackage

### hdl/lpwa_if.sv
// input channel
interface lpwa_in_if;
    logic                valid;
    logic                ready;
    lpwa_pkg::lpwa_in_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// output channel
interface lpwa_out_if;
    logic                valid;
    logic                ready;
    lpwa_pkg::lpwa_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/lpwa_div.sv
module lpwa_div #(
    parameter int SUM_W = 20
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [SUM_W-1:0]    dividend,
    input  logic [lpwa_pkg::WIN_W-1:0] divisor,
    output logic                       done,
    output logic [lpwa_pkg::DATA_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [lpwa_pkg::WIN_W-1:0]  rem_reg, rem_next;
    logic [lpwa_pkg::WIN_W-1:0]  dvs_reg;
    logic [SUM_W-1:0]            quo_reg, quo_next;
    logic                        neg_reg;
    logic [lpwa_pkg::WIN_W:0]    trial;
    logic                        ge;
    logic [lpwa_pkg::WIN_W:0]    diff;
    logic [SUM_W-1:0]            mag;

    // magnitude of the dividend
    assign mag = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

    // one restoring step
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    // step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = mag;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[lpwa_pkg::WIN_W-1:0] : trial[lpwa_pkg::WIN_W-1:0];
            quo_next  = {quo_reg[SUM_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            neg_reg <= dividend[SUM_W-1];
            dvs_reg <= divisor;
        end
    end

    // signed result, truncated toward zero
    assign done     = done_reg;
    assign quotient = lpwa_pkg::DATA_W'(neg_reg ? (~quo_reg + 1'b1) : quo_reg);

    // checks
    a_no_restart : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_last : assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start && step_reg == STEP_LAST |=> done_reg && !busy_reg)
        else $error("divider did not finish after its last step");

endmodule

### hdl/lpwa_ctrl.sv
module lpwa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lpwa_pkg::lpwa_stat_t stat,
    output lpwa_pkg::lpwa_cmd_t  cmd
);

    lpwa_pkg::lpwa_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lpwa_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpwa_pkg::S_IDLE:
                if (in_valid)
                    state_next = lpwa_pkg::S_MEAS;
            lpwa_pkg::S_MEAS:
                state_next = lpwa_pkg::S_OVR;
            lpwa_pkg::S_OVR:
                state_next = lpwa_pkg::S_DECIDE;
            lpwa_pkg::S_DECIDE:
                if (stat.fill_all || (stat.avg_now && stat.ovr_item))
                    state_next = lpwa_pkg::S_FILL;
                else if (stat.avg_now)
                    state_next = lpwa_pkg::S_READ;
                else
                    state_next = lpwa_pkg::S_OUT;
            lpwa_pkg::S_FILL:
                if (stat.sweep_last)
                    state_next = lpwa_pkg::S_OUT;
            lpwa_pkg::S_READ:
                if (stat.sweep_last)
                    state_next = lpwa_pkg::S_DRAIN;
            lpwa_pkg::S_DRAIN:
                state_next = lpwa_pkg::S_DIV_START;
            lpwa_pkg::S_DIV_START:
                state_next = lpwa_pkg::S_DIV_WAIT;
            lpwa_pkg::S_DIV_WAIT:
                if (stat.div_done)
                    state_next = stat.lane_last ? lpwa_pkg::S_OUT : lpwa_pkg::S_DIV_START;
            lpwa_pkg::S_OUT:
                if (stat.out_free)
                    state_next = lpwa_pkg::S_IDLE;
            default:
                state_next = lpwa_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            lpwa_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            lpwa_pkg::S_MEAS:
                cmd.meas_step = 1'b1;
            lpwa_pkg::S_OVR:
                cmd.ovr_step = 1'b1;
            lpwa_pkg::S_DECIDE:
                cmd.decide = 1'b1;
            lpwa_pkg::S_FILL:
                cmd.fill = 1'b1;
            lpwa_pkg::S_READ:
                cmd.read = 1'b1;
            lpwa_pkg::S_DIV_START:
                cmd.div_start = 1'b1;
            lpwa_pkg::S_DIV_WAIT:
                cmd.lane_next = stat.div_done && !stat.lane_last;
            lpwa_pkg::S_OUT:
                cmd.load_out = stat.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

### hdl/lpwa_dpath.sv
module lpwa_dpath #(
    parameter int WINDOW_MAX = 8,
    parameter int GROUPS     = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [lpwa_pkg::WIN_W-1:0] cfg_data,
    input  lpwa_pkg::lpwa_in_t         in_data,
    input  logic                       out_ready,
    output logic                       out_valid,
    output lpwa_pkg::lpwa_out_t        out_data,
    input  lpwa_pkg::lpwa_cmd_t        cmd,
    output lpwa_pkg::lpwa_stat_t       stat
);

    localparam int PTR_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int GRP_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int DEPTH   = GROUPS * WINDOW_MAX;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int W_CAP   = (WINDOW_MAX < 15) ? WINDOW_MAX : 15;
    localparam int SUM_W   = lpwa_pkg::DATA_W + 1 + $clog2(W_CAP);
    localparam int SWP_MAX = (WINDOW_MAX > 15) ? WINDOW_MAX : 15;
    localparam int SWP_W   = $clog2(SWP_MAX + 1);
    localparam int EXT_W   = SUM_W - lpwa_pkg::DATA_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_MAX - 1);

    localparam int DW = lpwa_pkg::DATA_W;
    localparam int CW = lpwa_pkg::CNT_W;
    localparam int NC = lpwa_pkg::NUM_COMP;

    // configuration and captured beat
    logic [lpwa_pkg::WIN_W-1:0] win_len_reg;
    lpwa_pkg::lpwa_in_t         item_reg;
    logic [lpwa_pkg::WIN_W-1:0] w_reg, w_capt;
    logic                       grp_ok_reg;

    // per group state
    logic [CW-1:0]    count_reg [GROUPS];
    logic [CW-1:0]    count_next [GROUPS];
    logic [PTR_W-1:0] wp_reg [GROUPS];
    logic [PTR_W-1:0] wp_next [GROUPS];

    // per item state
    logic             fill_all_reg;
    logic             avg_reg;
    logic [CW-1:0]    cnt_out_reg;
    logic [PTR_W-1:0] swp_ptr_reg;
    logic [SWP_W-1:0] swp_left_reg;
    logic             rd_valid_reg;
    lpwa_pkg::lpwa_vec_t rd_data_reg;
    logic signed [SUM_W-1:0] acc_reg [NC];
    logic [lpwa_pkg::COMP_W-1:0] lane_reg;
    logic [DW-1:0]    q_reg [NC];

    // output register
    logic                out_valid_reg;
    lpwa_pkg::lpwa_out_t out_reg;

    // ring memory
    lpwa_pkg::lpwa_vec_t mem [DEPTH];

    logic [GRP_W-1:0]  gidx;
    logic [CW-1:0]     cur_count;
    logic [PTR_W-1:0]  cur_wp;
    logic [PTR_W-1:0]  wp_inc;
    logic [CW-1:0]     cnt_inc;
    logic              meas_do, ovr_do, bump;
    logic [CW-1:0]     w_ext;
    logic              avg_now;
    logic [ADDR_W-1:0] base;
    logic [PTR_W-1:0]  ptr_up, ptr_dn, wp_prev;
    lpwa_pkg::lpwa_vec_t meas_vec, ovr_vec, res_vec;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    lpwa_pkg::lpwa_vec_t mem_wdata;
    logic              div_done;
    logic [DW-1:0]     div_q;
    logic              out_free;

    // window clamped to 1..WINDOW_MAX
    always_comb
    begin
        if (win_len_reg == '0)
            w_capt = lpwa_pkg::WIN_W'(1);
        else if (32'(win_len_reg) > WINDOW_MAX)
            w_capt = lpwa_pkg::WIN_W'(WINDOW_MAX);
        else
            w_capt = win_len_reg;
    end

    // group lookup
    assign gidx      = GRP_W'(item_reg.lane_group);
    assign cur_count = grp_ok_reg ? count_reg[gidx] : '0;
    assign cur_wp    = grp_ok_reg ? wp_reg[gidx] : '0;
    assign wp_inc    = (cur_wp == PTR_LAST) ? '0 : cur_wp + 1'b1;
    assign wp_prev   = (cur_wp == '0) ? PTR_LAST : cur_wp - 1'b1;
    assign cnt_inc   = (cur_count == lpwa_pkg::CNT_MAX) ? cur_count : cur_count + 1'b1;
    assign meas_do   = grp_ok_reg && item_reg.lane_present && item_reg.measure_valid;
    assign ovr_do    = grp_ok_reg && item_reg.lane_present && item_reg.override_on;
    assign bump      = (cmd.meas_step && meas_do) || (cmd.ovr_step && ovr_do);
    assign w_ext     = CW'(w_reg);
    assign avg_now   = grp_ok_reg && (cur_count >= w_ext);
    assign base      = ADDR_W'(32'(gidx) * WINDOW_MAX);

    // sweep pointer steps
    assign ptr_up = (swp_ptr_reg == PTR_LAST) ? '0 : swp_ptr_reg + 1'b1;
    assign ptr_dn = (swp_ptr_reg == '0) ? PTR_LAST : swp_ptr_reg - 1'b1;

    // component vectors
    assign meas_vec[0] = item_reg.dir_x;
    assign meas_vec[1] = item_reg.dir_y;
    assign meas_vec[2] = item_reg.base_x;
    assign meas_vec[3] = item_reg.base_y;
    assign ovr_vec[0]  = item_reg.ovr_dir_x;
    assign ovr_vec[1]  = item_reg.ovr_dir_y;
    assign ovr_vec[2]  = item_reg.ovr_base_x;
    assign ovr_vec[3]  = item_reg.ovr_base_y;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_len_reg <= lpwa_pkg::WIN_RESET;
        else if (cfg_we)
            win_len_reg <= cfg_data;
    end

    // captured beat
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
            w_reg    <= w_capt;
        end
    end

    // count and write pointer updates
    always_comb
    begin
        count_next = count_reg;
        wp_next    = wp_reg;
        if (bump)
        begin
            count_next[gidx] = cnt_inc;
            wp_next[gidx]    = wp_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GROUPS; i++)
            begin
                count_reg[i] <= '0;
                wp_reg[i]    <= '0;
            end
        end
        else
        begin
            count_reg <= count_next;
            wp_reg    <= wp_next;
        end
    end

    // per item control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_ok_reg   <= 1'b0;
            fill_all_reg <= 1'b0;
            avg_reg      <= 1'b0;
            swp_ptr_reg  <= '0;
            swp_left_reg <= '0;
            rd_valid_reg <= 1'b0;
            lane_reg     <= '0;
        end
        else
        begin
            rd_valid_reg <= cmd.read;
            if (cmd.capture)
            begin
                grp_ok_reg   <= (32'(in_data.lane_group) < GROUPS);
                fill_all_reg <= 1'b0;
            end
            if (cmd.ovr_step && ovr_do)
                fill_all_reg <= (cur_count < w_ext);
            if (cmd.decide)
            begin
                avg_reg  <= avg_now;
                lane_reg <= '0;
                if (fill_all_reg)
                begin
                    swp_ptr_reg  <= '0;
                    swp_left_reg <= SWP_W'(WINDOW_MAX);
                end
                else
                begin
                    swp_ptr_reg  <= wp_prev;
                    swp_left_reg <= SWP_W'(w_reg);
                end
            end
            if (cmd.fill || cmd.read)
            begin
                swp_left_reg <= swp_left_reg - 1'b1;
                swp_ptr_reg  <= fill_all_reg ? ptr_up : ptr_dn;
            end
            if (cmd.lane_next)
                lane_reg <= lane_reg + 1'b1;
        end
    end

    // count reported with the result
    always_ff @(posedge clk)
    begin
        if (cmd.decide)
            cnt_out_reg <= cur_count;
    end

    // ring write and read ports
    assign mem_we    = (cmd.meas_step && meas_do) || cmd.fill;
    assign mem_wdata = cmd.fill ? ovr_vec : meas_vec;
    assign mem_waddr = base + ADDR_W'(cmd.fill ? swp_ptr_reg : cur_wp);
    assign mem_raddr = base + ADDR_W'(swp_ptr_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (cmd.read)
            rd_data_reg <= mem[mem_raddr];
    end

    // window sums
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NC; c++)
        begin
            if (cmd.decide)
                acc_reg[c] <= '0;
            else if (rd_valid_reg)
                acc_reg[c] <= acc_reg[c] + {{EXT_W{rd_data_reg[c][DW-1]}}, rd_data_reg[c]};
        end
    end

    // shared divider, one component at a time
    lpwa_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (acc_reg[lane_reg]),
        .divisor  (w_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (div_done)
            q_reg[lane_reg] <= div_q;
    end

    // result selection
    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            if (!avg_reg)
                res_vec[c] = '0;
            else if (item_reg.override_on)
                res_vec[c] = ovr_vec[c];
            else
                res_vec[c] = q_reg[c];
        end
    end

    // output register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.out_group     <= item_reg.lane_group;
            out_reg.average_valid <= avg_reg;
            out_reg.avg_dir_x     <= res_vec[0];
            out_reg.avg_dir_y     <= res_vec[1];
            out_reg.avg_base_x    <= res_vec[2];
            out_reg.avg_base_y    <= res_vec[3];
            out_reg.entry_count   <= cnt_out_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // status to the controller
    assign stat.fill_all   = fill_all_reg;
    assign stat.avg_now    = avg_now;
    assign stat.ovr_item   = item_reg.override_on;
    assign stat.sweep_last = (swp_left_reg == SWP_W'(1));
    assign stat.div_done   = div_done;
    assign stat.lane_last  = (lane_reg == lpwa_pkg::COMP_LAST);
    assign stat.out_free   = out_free;

    // checks
    a_fill_needs_override : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill |-> item_reg.override_on && grp_ok_reg)
        else $error("ring fill without an override on a known group");

    a_read_only_averaging : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |-> avg_reg && !item_reg.override_on)
        else $error("ring read outside an averaging pass");

    a_valid_count : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out && avg_reg |-> cnt_out_reg >= w_ext)
        else $error("average flagged valid below the window length");

endmodule

### hdl/lane_param_window_average.sv
// Boxcar average of lane estimates for up to GROUPS lane groups.
// in_ch carries one frame's estimate for one group (direction and base
// point, measured and override values); out_ch carries one result beat per
// input beat, in the same order. cfg_we/cfg_data write the window length,
// which the user must do only while the block is idle (not enforced).
// An input beat is taken only in the idle state. Measurement write and count
// update happen in the measurement state after acceptance; an override fill
// writes up to WINDOW_MAX ring entries. An averaging beat without an override
// reads the window one entry a cycle through the ring memory's single read
// port, then one shared bit-serial divider produces the four means in turn.
// The result sits in an output register; the next input beat is accepted
// while it waits, and a stalled receiver only holds the block once a second
// result is ready.
// Reset clears counts and write pointers and sets the window length to 6;
// ring contents are left as they are and are written before they are read.
module lane_param_window_average #(
    parameter int WINDOW_MAX = 8,
    parameter int GROUPS     = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [lpwa_pkg::WIN_W-1:0] cfg_data,
    lpwa_in_if.sink                    in_ch,
    lpwa_out_if.source                 out_ch
);

    lpwa_pkg::lpwa_cmd_t  cmd;
    lpwa_pkg::lpwa_stat_t stat;
    logic                 in_ready;
    logic                 out_valid;
    lpwa_pkg::lpwa_out_t  out_data;

    // sequencing
    lpwa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // ring, sums, divider and output register
    lpwa_dpath #(
        .WINDOW_MAX (WINDOW_MAX),
        .GROUPS     (GROUPS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_data   (in_ch.data),
        .out_ready (out_ch.ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    // channel hookup
    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid;
    assign out_ch.data  = out_data;

endmodule
